[hdl/feal8_pkg.sv]
// Shared types and the FEAL-8 S-box, f and fK functions.
package feal8_pkg;

    localparam int NumRounds = 8;
    localparam int NumSubkeys = 16;

    typedef logic [15:0] subkey_t;
    typedef logic [NumSubkeys-1:0][15:0] subkeys_t;

    // Left and right halves of a block in flight, with its direction.
    typedef struct packed {
        logic        dec;
        logic [31:0] l;
        logic [31:0] r;
    } half_pair_t;

    // Status of the key expansion unit.
    typedef struct packed {
        logic busy;
    } ks_status_t;

    function automatic logic [7:0] rot2(input logic [7:0] x);
        return {x[5:0], x[7:6]};
    endfunction

    function automatic logic [7:0] sbox0(input logic [7:0] x, input logic [7:0] y);
        logic [7:0] s;
        s = x + y;
        return rot2(s);
    endfunction

    function automatic logic [7:0] sbox1(input logic [7:0] x, input logic [7:0] y);
        logic [7:0] s;
        s = x + y + 8'd1;
        return rot2(s);
    endfunction

    // Round function f; byte 0 is the most significant byte.
    function automatic logic [31:0] f_round(input logic [31:0] a, input subkey_t k);
        logic [7:0] f0;
        logic [7:0] f1;
        logic [7:0] f2;
        logic [7:0] f3;
        f1 = a[23:16] ^ k[15:8] ^ a[31:24];
        f2 = a[15:8] ^ k[7:0] ^ a[7:0];
        f1 = sbox1(f1, f2);
        f2 = sbox0(f2, f1);
        f0 = sbox0(a[31:24], f1);
        f3 = sbox1(a[7:0], f2);
        return {f0, f1, f2, f3};
    endfunction

    // Key schedule function fK.
    function automatic logic [31:0] fk_mix(input logic [31:0] a, input logic [31:0] b);
        logic [7:0] t1;
        logic [7:0] t2;
        logic [7:0] y0;
        logic [7:0] y3;
        t1 = a[31:24] ^ a[23:16];
        t2 = a[15:8] ^ a[7:0];
        t1 = sbox1(t1, t2 ^ b[31:24]);
        t2 = sbox0(t2, t1 ^ b[23:16]);
        y0 = sbox0(a[31:24], t1 ^ b[15:8]);
        y3 = sbox1(a[7:0], t2 ^ b[7:0]);
        return {y0, t1, t2, y3};
    endfunction

endpackage

[hdl/feal8_key_sched.sv]
// Key expansion unit: one fK iteration per cycle into the subkey registers.
module feal8_key_sched (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cipher_key_we,
    input  logic [63:0]           cipher_key,
    output feal8_pkg::subkeys_t   subkeys,
    output feal8_pkg::ks_status_t status
);
    import feal8_pkg::*;

    logic [31:0] a_reg;
    logic [31:0] b_reg;
    logic [31:0] d_reg;
    logic [2:0]  cnt_reg;
    logic        busy_reg;
    subkeys_t    sub_reg;
    logic [31:0] nb_next;

    assign nb_next = fk_mix(a_reg, b_reg ^ d_reg);

    // Reset starts an expansion of the all-zero key.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg    <= '0;
            b_reg    <= '0;
            d_reg    <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
        end
        else if (cipher_key_we)
        begin
            a_reg    <= cipher_key[63:32];
            b_reg    <= cipher_key[31:0];
            d_reg    <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
        end
        else if (busy_reg)
        begin
            d_reg   <= a_reg;
            a_reg   <= b_reg;
            b_reg   <= nb_next;
            cnt_reg <= cnt_reg + 3'd1;
            if (cnt_reg == 3'(NumRounds - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && !cipher_key_we)
        begin
            sub_reg[{cnt_reg, 1'b0}] <= nb_next[31:16];
            sub_reg[{cnt_reg, 1'b1}] <= nb_next[15:0];
        end
    end

    assign subkeys     = sub_reg;
    assign status.busy = busy_reg;

endmodule

[hdl/feal8_round_cell.sv]
// One Feistel round cell with its own pipeline register and valid bit.
module feal8_round_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  up_valid,
    output logic                  up_ready,
    input  feal8_pkg::half_pair_t up_data,
    input  feal8_pkg::subkey_t    enc_key,
    input  feal8_pkg::subkey_t    dec_key,
    output logic                  dn_valid,
    input  logic                  dn_ready,
    output feal8_pkg::half_pair_t dn_data
);
    import feal8_pkg::*;

    logic       valid_reg;
    half_pair_t data_reg;
    half_pair_t data_next;
    subkey_t    key;

    always_comb
    begin
        key         = up_data.dec ? dec_key : enc_key;
        data_next.dec = up_data.dec;
        data_next.l   = up_data.r;
        data_next.r   = up_data.l ^ f_round(up_data.r, key);
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

[hdl/feal8_block_cipher.sv]
// Top level of the FEAL-8 block cipher: key expansion and a chain of round cells.
//
//   channel   | handshake                   | payload
//   ----------+-----------------------------+-----------------------------
//   input     | valid / stall               | action, data_block
//   result    | result_valid / result_stall | result_block
//   key write | cipher_key_we               | cipher_key
//
// An accepted item is registered in round cell 0, moves on through cells 1 to 7
// in turn, and is then loaded into the output register, which applies the final
// mix and whitening.
// A new item is accepted every cycle while the chain flows.
// Reset and every key write start a key expansion (one fK step per cycle);
// input stall is held high during it. A result stall holds the output register.
// Full cells pass the hold back toward the input in the same cycle, and empty
// cells keep taking items, so back-pressure raises input stall only when every
// cell is full.
module feal8_block_cipher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cipher_key_we,
    input  logic [63:0] cipher_key,
    input  logic        valid,
    output logic        stall,
    input  logic        action,
    input  logic [63:0] data_block,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [63:0] result_block
);
    import feal8_pkg::*;

    subkeys_t   subkeys;
    ks_status_t ks_status;

    // Link 0 is the whitened input; link i+1 is the output of round cell i.
    half_pair_t link_data  [NumRounds+1];
    logic       link_valid [NumRounds+1];
    logic       link_ready [NumRounds+1];

    logic [63:0] w_in;
    logic [63:0] w_out;
    logic [63:0] blk_in;
    logic [31:0] final_l;
    logic        result_valid_reg;
    logic [63:0] result_reg;
    logic [63:0] result_next;

    feal8_key_sched u_key_sched (
        .clk           (clk),
        .rst_n         (rst_n),
        .cipher_key_we (cipher_key_we),
        .cipher_key    (cipher_key),
        .subkeys       (subkeys),
        .status        (ks_status)
    );

    // Input whitening uses K8..K11 to encrypt and K12..K15 to decrypt, then the
    // right half is mixed with the left.
    always_comb
    begin
        w_in = action ? {subkeys[12], subkeys[13], subkeys[14], subkeys[15]}
                      : {subkeys[8], subkeys[9], subkeys[10], subkeys[11]};
        blk_in            = data_block ^ w_in;
        link_data[0].dec  = action;
        link_data[0].l    = blk_in[63:32];
        link_data[0].r    = blk_in[31:0] ^ blk_in[63:32];
    end

    assign link_valid[0] = valid && !ks_status.busy;
    assign stall         = ks_status.busy || !link_ready[0];

    // Round i uses subkey i to encrypt and subkey 7-i to decrypt; each item
    // carries its own direction down the chain.
    for (genvar i = 0; i < NumRounds; i++)
    begin : g_round
        feal8_round_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (link_valid[i]),
            .up_ready (link_ready[i]),
            .up_data  (link_data[i]),
            .enc_key  (subkeys[i]),
            .dec_key  (subkeys[NumRounds-1-i]),
            .dn_valid (link_valid[i+1]),
            .dn_ready (link_ready[i+1]),
            .dn_data  (link_data[i+1])
        );
    end

    // The last round leaves the halves swapped; they go out as (R, L ^ R)
    // followed by the output whitening.
    always_comb
    begin
        w_out = link_data[NumRounds].dec
              ? {subkeys[8], subkeys[9], subkeys[10], subkeys[11]}
              : {subkeys[12], subkeys[13], subkeys[14], subkeys[15]};
        final_l     = link_data[NumRounds].l ^ link_data[NumRounds].r;
        result_next = {link_data[NumRounds].r, final_l} ^ w_out;
    end

    assign link_ready[NumRounds] = !result_valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (link_ready[NumRounds])
        begin
            result_valid_reg <= link_valid[NumRounds];
        end
    end

    always_ff @(posedge clk)
    begin
        if (link_ready[NumRounds] && link_valid[NumRounds])
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_block = result_reg;

`ifndef ASSERT_OFF
    // A key write always holds off input while the new subkeys are built.
    a_key_write_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        cipher_key_we |=> stall)
        else $error("input not stalled after key write");

    // Key expansion never ends early.
    a_expand_length: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(ks_status.busy) |-> $past(ks_status.busy, 7))
        else $error("key expansion ended early");

    // A result only appears when the last round cell held an item.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(link_valid[NumRounds]))
        else $error("result appeared without a finished item");
`endif

endmodule
